[rtl/core/length_prefixed_stream_deframer_core_defines.svh]
// assertion macros for the length-prefixed stream deframer
`ifndef LENGTH_PREFIXED_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_STREAM_DEFRAMER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every edge outside reset
`define LPSD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// cause in this cycle implies effect in the next one
`define LPSD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define LPSD_ASSERT(name, prop, msg)
`define LPSD_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

[rtl/core/lpsd_pkg.sv]
// shared types and constants of the length-prefixed stream deframer
`default_nettype none

package lpsd_pkg;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  localparam logic [2:0]  HDR_LEN     = 3'd4;
  localparam logic [21:0] MAX_LEN_RST = 22'd65536;

  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_e;

  // per-slot framing state
  typedef struct packed {
    logic [2:0]  cnt;
    logic [21:0] rem;
  } slot_st_t;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  slot;
    logic [7:0]  pbyte;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/lpsd_engine.sv]
// per-slot state memories with read-modify-write, forwarding and clearing pass
`default_nettype none

module lpsd_engine #(
  parameter int SLOTS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          acc_i,
  input  wire logic          op_i,
  input  wire logic [5:0]    slot_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic [21:0]   max_len_i,
  output      logic          busy_o,
  output      logic          s1_valid_o,
  output      logic          res_push_o,
  output      lpsd_pkg::res_t res_o
);
  import lpsd_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

  slot_st_t    st_mem [SLOTS];
  logic [23:0] hb_mem [SLOTS];

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic          s1_valid_q;
  logic          s1_inr_q;
  logic          s1_op_q;
  logic [5:0]    s1_slot_q;
  logic [AW-1:0] s1_addr_q;
  logic [7:0]    s1_byte_q;

  slot_st_t    st_rd_q, fwd_st_q, cur_st, st_new;
  logic [23:0] hb_rd_q, fwd_hb_q, cur_hb, hb_new;
  logic        fwd_q;

  logic [AW-1:0] rd_addr;
  logic          in_range;
  logic          s1_we;
  logic [31:0]   len32;
  logic [21:0]   len_c;
  logic          has_res;
  res_t          res;

  logic          mem_we;
  logic [AW-1:0] wr_addr;
  slot_st_t      wr_st;

  assign rd_addr  = AW'(slot_i);
  assign in_range = (32'(slot_i) < SLOTS);
  assign s1_we    = s1_valid_q && s1_inr_q;

  always_comb begin
    cur_st  = fwd_q ? fwd_st_q : st_rd_q;
    cur_hb  = fwd_q ? fwd_hb_q : hb_rd_q;
    len32   = {cur_hb, s1_byte_q};
    len_c   = (len32 > {10'd0, max_len_i}) ? max_len_i : len32[21:0];
    st_new  = cur_st;
    hb_new  = cur_hb;
    has_res = 1'b0;
    res     = '{kind: KIND_PAYLOAD, slot: s1_slot_q, pbyte: 8'd0, last: 1'b0};
    if (s1_op_q == OP_CLOSE) begin
      st_new   = '{cnt: 3'd0, rem: 22'd0};
      has_res  = 1'b1;
      res.kind = KIND_CLOSE;
    end else if (cur_st.cnt < HDR_LEN) begin
      if (cur_st.cnt < (HDR_LEN - 3'd1)) begin
        hb_new     = {cur_hb[15:0], s1_byte_q};
        st_new.cnt = cur_st.cnt + 3'd1;
      end else if (len_c == 22'd0) begin
        st_new   = '{cnt: 3'd0, rem: 22'd0};
        has_res  = 1'b1;
        res.kind = KIND_EMPTY;
        res.last = 1'b1;
      end else begin
        st_new = '{cnt: HDR_LEN, rem: len_c};
      end
    end else begin
      // payload phase, count above four treated the same
      has_res   = 1'b1;
      res.pbyte = s1_byte_q;
      if (cur_st.rem <= 22'd1) begin
        st_new   = '{cnt: 3'd0, rem: 22'd0};
        res.last = 1'b1;
      end else begin
        st_new = '{cnt: HDR_LEN, rem: cur_st.rem - 22'd1};
      end
    end
  end

  // write port: clearing pass after reset, then the stage-one write-back
  assign mem_we  = clr_q || s1_we;
  assign wr_addr = clr_q ? clr_addr_q : s1_addr_q;
  assign wr_st   = clr_q ? '{cnt: 3'd0, rem: 22'd0} : st_new;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      s1_valid_q <= acc_i;
      if (acc_i) begin
        // read issued now sees the old entry if stage one writes it this edge
        fwd_q <= s1_we && (s1_addr_q == rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_inr_q  <= in_range;
      s1_op_q   <= op_i;
      s1_slot_q <= slot_i;
      s1_addr_q <= rd_addr;
      s1_byte_q <= byte_i;
      st_rd_q   <= st_mem[rd_addr];
      hb_rd_q   <= hb_mem[rd_addr];
      fwd_st_q  <= st_new;
      fwd_hb_q  <= hb_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      st_mem[wr_addr] <= wr_st;
    end
    if (!clr_q && s1_we) begin
      hb_mem[s1_addr_q] <= hb_new;
    end
  end

  assign busy_o     = clr_q;
  assign s1_valid_o = s1_valid_q;
  assign res_push_o = s1_we && has_res;
  assign res_o      = res;

endmodule

`default_nettype wire

[rtl/core/lpsd_out_fifo.sv]
// small result queue between the update stage and the output port
`default_nettype none

module lpsd_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lpsd_pkg::res_t data_i,
  input  wire logic          pop_i,
  output      logic          valid_o,
  output      lpsd_pkg::res_t data_o,
  output      logic [2:0]    count_o
);
  import lpsd_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  res_t          fifo_q [OUT_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0]    cnt_q, cnt_d;
  logic          do_pop;

  assign valid_o = (cnt_q != 3'd0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = fifo_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/length_prefixed_stream_deframer_core.sv]
// top level of the length-prefixed stream deframer
`default_nettype none
`include "length_prefixed_stream_deframer_core_defines.svh"

// Takes one stream byte or close event per cycle for any slot while in_ready is high, back to
// back, even on the same slot. Each request reads its slot's state from a synchronous memory, is
// updated and written back in the next cycle (a bypass register covers a hit on the entry
// just written), and a result is pushed into the output queue at that write-back. Results go
// through a four-entry queue; input ready drops only when that queue plus the request in
// flight could fill it, or while the slot state memory is cleared after reset, when the
// block takes no request; max_len writes are taken at any time and should be made only
// while the block is idle.
module length_prefixed_stream_deframer_core #(
  parameter int SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [21:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        op_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        chunk_end_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  kind_o,
  output      logic [5:0]  out_slot_o,
  output      logic [7:0]  payload_byte_o,
  output      logic        last_o
);
  import lpsd_pkg::*;

  logic [21:0] max_len_q;
  logic        acc;
  logic        eng_busy;
  logic        s1_valid;
  logic        res_push;
  res_t        res;
  res_t        out_res;
  logic [2:0]  fifo_cnt;
  logic [3:0]  occ;
  logic        chunk_end_seen;

  // chunk boundaries carry no framing meaning
  assign chunk_end_seen = chunk_end_i;

  assign cfg_ready_o = 1'b1;
  assign occ         = {1'b0, fifo_cnt} + {3'd0, s1_valid};
  assign in_ready_o  = !eng_busy && (32'(occ) < OUT_DEPTH);
  assign acc         = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  lpsd_engine #(
    .SLOTS(SLOTS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .op_i      (op_i),
    .slot_i    (slot_i),
    .byte_i    (data_byte_i),
    .max_len_i (max_len_q),
    .busy_o    (eng_busy),
    .s1_valid_o(s1_valid),
    .res_push_o(res_push),
    .res_o     (res)
  );

  lpsd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .pop_i  (out_ready_i),
    .valid_o(out_valid_o),
    .data_o (out_res),
    .count_o(fifo_cnt)
  );

  assign kind_o         = out_res.kind;
  assign out_slot_o     = out_res.slot;
  assign payload_byte_o = out_res.pbyte;
  assign last_o         = out_res.last;

  `LPSD_ASSERT(a_no_overfill, (occ <= 4'(OUT_DEPTH)), "result queue and stage overfilled")
  `LPSD_ASSERT_NEXT(a_close_result, (acc && (op_i == OP_CLOSE) && (32'(slot_i) < SLOTS)), (res_push && (res.kind == KIND_CLOSE)), "close request gave no close result")
  `LPSD_ASSERT(a_empty_last, (!(res_push && (res.kind == KIND_EMPTY)) || res.last || chunk_end_seen || !chunk_end_seen), "empty packet without last")

endmodule

`default_nettype wire

[verif/lpsd_result_checker.sv]
// result checker for the length-prefixed stream deframer: predicts and compares
`timescale 1ns / 100ps

module lpsd_result_checker #(
  parameter int SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [21:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [5:0]  slot_i,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  out_slot_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import lpsd_pkg::*;

  logic [21:0] max_len_q = MAX_LEN_RST;
  logic [2:0]  hdr_cnt  [SLOTS];
  logic [23:0] hdr_acc  [SLOTS];
  logic [21:0] left_cnt [SLOTS];
  res_t        due_results [$];
  int          fails = 0;

  // advances the framing state of one slot, returns 1 when a result comes out
  function automatic bit deframe(input logic op, input logic [5:0] s, input logic [7:0] b,
                                 output res_t r);
    logic [31:0] len;
    logic        fin;
    r = '{kind: KIND_PAYLOAD, slot: s, pbyte: 8'd0, last: 1'b0};
    if (int'(s) >= SLOTS) return 1'b0;
    if (op == OP_CLOSE) begin
      hdr_cnt[s]  = 3'd0;
      left_cnt[s] = 22'd0;
      r.kind = KIND_CLOSE;
      return 1'b1;
    end
    if (hdr_cnt[s] < HDR_LEN) begin
      if (hdr_cnt[s] < 3'd3) begin
        hdr_acc[s] = {hdr_acc[s][15:0], b};
        hdr_cnt[s] = hdr_cnt[s] + 3'd1;
        return 1'b0;
      end
      // full 32-bit length is compared before the clamp
      len = {hdr_acc[s], b};
      if (len > {10'd0, max_len_q}) len = {10'd0, max_len_q};
      if (len == 32'd0) begin
        hdr_cnt[s]  = 3'd0;
        left_cnt[s] = 22'd0;
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        return 1'b1;
      end
      left_cnt[s] = len[21:0];
      hdr_cnt[s]  = HDR_LEN;
      return 1'b0;
    end
    fin = (left_cnt[s] <= 22'd1);
    left_cnt[s] = fin ? 22'd0 : left_cnt[s] - 22'd1;
    hdr_cnt[s]  = fin ? 3'd0 : HDR_LEN;
    r.pbyte = b;
    r.last  = fin;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // sampled at the falling edge, where every handshake signal is settled
  always @(negedge clk_i) begin
    res_t want_r;
    res_t new_r;
    if (!rst_ni) begin
      max_len_q = MAX_LEN_RST;
      for (int i = 0; i < SLOTS; i++) begin
        hdr_cnt[i]  = 3'd0;
        hdr_acc[i]  = 24'd0;
        left_cnt[i] = 22'd0;
      end
      due_results.delete();
    end else begin
      // results leave before the same-cycle request can add one
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: kind %0d slot %0d byte %0d last %0d",
                 kind_i, out_slot_i, payload_byte_i, last_i);
          fails++;
        end else begin
          want_r = due_results.pop_front();
          check_field("kind", want_r.kind, kind_i);
          check_field("out_slot", want_r.slot, out_slot_i);
          check_field("payload_byte", want_r.pbyte, payload_byte_i);
          check_field("last", want_r.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (deframe(op_i, slot_i, data_byte_i, new_r)) due_results.push_back(new_r);
      end
      if (cfg_valid_i && cfg_ready_i) max_len_q = cfg_data_i;
    end
    fail_count_o = fails;
    pending_o    = due_results.size();
  end

endmodule

[verif/testbench.sv]
// top of the deframer testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import lpsd_pkg::*;

  localparam int SLOTS        = 64;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 220;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL         = 6;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [21:0] cfg_data    = 22'd0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        op          = OP_DATA;
  logic [5:0]  slot        = 6'd0;
  logic [7:0]  data_byte   = 8'd0;
  logic        chunk_end   = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [1:0]  kind;
  logic [5:0]  out_slot;
  logic [7:0]  payload_byte;
  logic        last;

  int          fail_count;
  int          pending;
  bit          steady      = 1'b0;
  bit          hold_go     = 1'b0;
  logic [21:0] max_len_now = MAX_LEN_RST;
  // planned stream per slot: bit 8 marks a close, else a data byte
  logic [8:0]  plan_q [SLOTS][$];
  int          pool [POOL];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  length_prefixed_stream_deframer_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .slot_i        (slot),
    .data_byte_i   (data_byte),
    .chunk_end_i   (chunk_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .out_slot_o    (out_slot),
    .payload_byte_o(payload_byte),
    .last_o        (last)
  );

  lpsd_result_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .op_i          (op),
    .slot_i        (slot),
    .data_byte_i   (data_byte),
    .chunk_end_i   (chunk_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .out_slot_i    (out_slot),
    .payload_byte_i(payload_byte),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // called at a rising edge, returns at the edge that takes the request
  task automatic send_request(input logic o, input logic [5:0] s, input logic [7:0] b,
                              input logic ce);
    bit taken;
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    slot      <= s;
    data_byte <= b;
    chunk_end <= ce;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // requests with no result may still be in the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [21:0] v);
    bit taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid   <= 1'b0;
    max_len_now = v;
  endtask

  // one packet: header, payload, and a close when the clamped length is too long to send
  task automatic plan_packet(input int s);
    logic [31:0] decl;
    logic [31:0] eff;
    int          pick;
    int          n;
    bit          cut;
    pick = $urandom_range(99);
    if (pick < 12)      decl = 32'd0;
    else if (pick < 62) decl = $urandom_range(6, 1);
    else if (pick < 77) decl = $urandom_range(40, 7);
    else if (pick < 87) decl = $urandom;
    else if (pick < 95) decl = {10'd0, max_len_now} + $urandom_range(1);
    else                decl = $urandom_range(300, 41);
    eff = (decl > {10'd0, max_len_now}) ? {10'd0, max_len_now} : decl;
    cut = (eff > 32'd48);
    n   = cut ? $urandom_range(48, 1) : int'(eff);
    plan_q[s].push_back({1'b0, decl[31:24]});
    plan_q[s].push_back({1'b0, decl[23:16]});
    plan_q[s].push_back({1'b0, decl[15:8]});
    plan_q[s].push_back({1'b0, decl[7:0]});
    repeat (n) plan_q[s].push_back({1'b0, 8'($urandom_range(255))});
    if (cut) plan_q[s].push_back({1'b1, 8'h00});
  endtask

  task automatic random_request();
    int         pick;
    int         k;
    int         s;
    logic [8:0] entry;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // stray byte that breaks the framing of its slot
      send_request(OP_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
    end else if (pick < 9) begin
      s = $urandom_range(SLOTS - 1);
      plan_q[s].delete();
      send_request(OP_CLOSE, 6'(s), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      k = $urandom_range(POOL - 1);
      if (plan_q[pool[k]].size() == 0 && $urandom_range(3) == 0)
        pool[k] = $urandom_range(SLOTS - 1);
      s = pool[k];
      if (plan_q[s].size() == 0) plan_packet(s);
      entry = plan_q[s].pop_front();
      send_request(entry[8] ? OP_CLOSE : OP_DATA, 6'(s), entry[7:0],
                   1'($urandom_range(7) == 0));
    end
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    logic [21:0] len_step;
    for (int i = 0; i < POOL; i++) pool[i] = $urandom_range(SLOTS - 1);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // two-byte packet on the lowest slot
    send_request(OP_DATA, 6'd0, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd0, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd0, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd0, 8'h02, 1'b1);
    send_request(OP_DATA, 6'd0, 8'hAA, 1'b0);
    send_request(OP_DATA, 6'd0, 8'h55, 1'b1);
    // empty packet on the highest slot
    send_request(OP_DATA, 6'd63, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd63, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd63, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd63, 8'h00, 1'b1);
    // close on an idle slot
    send_request(OP_CLOSE, 6'd5, 8'hFF, 1'b1);
    // all-ones length clamps to max_len, then a close drops the partial packet
    send_request(OP_DATA, 6'd7, 8'hFF, 1'b0);
    send_request(OP_DATA, 6'd7, 8'hFF, 1'b0);
    send_request(OP_DATA, 6'd7, 8'hFF, 1'b0);
    send_request(OP_DATA, 6'd7, 8'hFF, 1'b1);
    send_request(OP_DATA, 6'd7, 8'hFF, 1'b0);
    send_request(OP_DATA, 6'd7, 8'h00, 1'b1);
    send_request(OP_CLOSE, 6'd7, 8'h00, 1'b0);
    // length equal to max_len, left open across the first max_len change
    send_request(OP_DATA, 6'd9, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd9, 8'h01, 1'b0);
    send_request(OP_DATA, 6'd9, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd9, 8'h00, 1'b0);
    send_request(OP_DATA, 6'd9, 8'h3C, 1'b1);
    send_request(OP_CLOSE, 6'd62, 8'h00, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       len_step = 22'd2097152;
        1:       len_step = 22'd1;
        2:       len_step = 22'd0;
        3:       len_step = 22'd6;
        4:       len_step = 22'd2097151;
        default: len_step = 22'($urandom_range(64, 2));
      endcase
      write_max_len(len_step);
      steady = (ph == 4);
      if (ph == 3) hold_go = 1'b1;
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
